// File: rtl/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg
// Shared types and constants for the group reverse stream block.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int unsigned MaxGroupDef = 16;
  localparam int unsigned ValW        = 32;
  localparam int unsigned GsW         = 5;

  // Move applied by every storage cell at once.
  typedef enum logic [1:0] {
    CellHold = 2'd0,
    CellPush = 2'd1,
    CellPop  = 2'd2
  } cell_op_e;

  typedef enum logic {
    StIdle  = 1'b0,
    StDrain = 1'b1
  } state_e;

endpackage

// File: rtl/grs_in_if.sv
// ----------------------------------------------------------------------------
// grs_in_if
// Input element channel: one sequence element and its final flag.
// ----------------------------------------------------------------------------
interface grs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [grs_pkg::ValW-1:0]   value;
  logic                              is_final;

  modport source (output valid, output value, output is_final, input ready);
  modport sink   (input valid, input value, input is_final, output ready);
endinterface

// File: rtl/grs_out_if.sv
// ----------------------------------------------------------------------------
// grs_out_if
// Result channel: emitted element with run and sequence end markers.
// ----------------------------------------------------------------------------
interface grs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [grs_pkg::ValW-1:0]   value_res;
  logic                              run_end;
  logic                              sequence_end;

  modport source (output valid, output value_res, output run_end, output sequence_end,
                  input ready);
  modport sink   (input valid, input value_res, input run_end, input sequence_end,
                  output ready);
endinterface

// File: rtl/grs_cfg_if.sv
// ----------------------------------------------------------------------------
// grs_cfg_if
// Configuration write channel carrying the group size.
// ----------------------------------------------------------------------------
interface grs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [grs_pkg::GsW-1:0]   group_size;

  modport source (output valid, output group_size, input ready);
  modport sink   (input valid, input group_size, output ready);
endinterface

// File: rtl/grs_cell.sv
// ----------------------------------------------------------------------------
// grs_cell
// One storage cell of the group buffer chain. A push takes the left
// neighbor's word, a pop takes the right neighbor's word.
// ----------------------------------------------------------------------------
module grs_cell (
  input  logic                            clk_i,
  input  grs_pkg::cell_op_e               op_i,
  input  logic signed [grs_pkg::ValW-1:0] left_i,
  input  logic signed [grs_pkg::ValW-1:0] right_i,
  output logic signed [grs_pkg::ValW-1:0] data_o
);

  logic signed [grs_pkg::ValW-1:0] data_d, data_q;

  always_comb begin
    case (op_i)
      grs_pkg::CellPush: data_d = left_i;
      grs_pkg::CellPop:  data_d = right_i;
      default:           data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: rtl/group_reverse_stream.sv
// ----------------------------------------------------------------------------
// group_reverse_stream
// Reverses a stream of signed 32-bit values in groups of a configured size;
// a trailing partial group leaves in its original order.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  ---------+-----------+--------------------------------------------
//  cfg_i    | in        | group_size (5 b, clamped to 1..MAX_GROUP)
//  in_i     | in        | value (32 b signed), is_final
//  out_o    | out       | value_res (32 b signed), run_end, sequence_end
//
//  Elements are taken one per cycle while idle, each pushed, the one that
//  closes a group too, into cell zero of the chain, older words moving one cell along.
//  A group of n elements then drains one result per cycle, while the output
//  accepts, into the output register; the input is held off during that drain.
//  Reversed groups pop the chain toward cell zero; a partial final group is
//  read oldest first by index. Reset clears control state only.
//  A stalled output holds the drain in place; nothing is dropped.
// ----------------------------------------------------------------------------
module group_reverse_stream #(
  parameter int unsigned MAX_GROUP = grs_pkg::MaxGroupDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  grs_cfg_if.sink    cfg_i,
  grs_in_if.sink     in_i,
  grs_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(MAX_GROUP + 1);
  localparam int unsigned IdxW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  grs_pkg::state_e   state_d, state_q;
  grs_pkg::cell_op_e cell_op;

  logic [CntW-1:0]          fill_d, fill_q;
  logic [CntW-1:0]          rem_d, rem_q;
  logic [CntW-1:0]          fill_next;
  logic                     rev_d, rev_q;
  logic                     fin_d, fin_q;
  logic [grs_pkg::GsW-1:0]  gs_d, gs_q;

  logic                     in_acc;
  logic                     emit;
  logic                     group_full;
  logic [IdxW-1:0]          sel_idx;

  logic                              out_valid_d, out_valid_q;
  logic signed [grs_pkg::ValW-1:0]   out_val_d, out_val_q;
  logic                              out_run_d, out_run_q;
  logic                              out_seq_d, out_seq_q;

  logic signed [grs_pkg::ValW-1:0] cell_data [MAX_GROUP];

  // Cell chain.
  for (genvar j = 0; j < MAX_GROUP; j++) begin : g_cell
    logic signed [grs_pkg::ValW-1:0] left_w, right_w;
    if (j == 0) begin : g_first
      assign left_w = in_i.value;
    end else begin : g_mid_l
      assign left_w = cell_data[j-1];
    end
    if (j == MAX_GROUP - 1) begin : g_last
      assign right_w = cell_data[j];
    end else begin : g_mid_r
      assign right_w = cell_data[j+1];
    end
    grs_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[j])
    );
  end

  // Configuration: zero becomes one, oversize becomes MAX_GROUP.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    gs_d = gs_q;
    if (cfg_i.valid) begin
      if (cfg_i.group_size == '0) begin
        gs_d = grs_pkg::GsW'(1);
      end else if (32'(cfg_i.group_size) > 32'(MAX_GROUP)) begin
        gs_d = grs_pkg::GsW'(MAX_GROUP);
      end else begin
        gs_d = cfg_i.group_size;
      end
    end
  end

  assign in_i.ready = (state_q == grs_pkg::StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign fill_next  = fill_q + CntW'(1);
  assign group_full = 32'(fill_next) >= 32'(gs_q);
  assign emit       = (state_q == grs_pkg::StDrain) && (!out_valid_q || out_o.ready);
  assign sel_idx    = IdxW'(rem_q - CntW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      grs_pkg::StIdle: begin
        if (in_acc && (group_full || in_i.is_final)) begin
          state_d = grs_pkg::StDrain;
        end
      end
      grs_pkg::StDrain: begin
        if (emit && rem_q == CntW'(1)) begin
          state_d = grs_pkg::StIdle;
        end
      end
      default: state_d = grs_pkg::StIdle;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    cell_op     = grs_pkg::CellHold;
    fill_d      = fill_q;
    rem_d       = rem_q;
    rev_d       = rev_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_val_d   = out_val_q;
    out_run_d   = out_run_q;
    out_seq_d   = out_seq_q;
    unique case (state_q)
      grs_pkg::StIdle: begin
        if (in_acc) begin
          cell_op = grs_pkg::CellPush;
          if (group_full || in_i.is_final) begin
            fill_d = '0;
            rem_d  = fill_next;
            rev_d  = group_full;
            fin_d  = in_i.is_final;
          end else begin
            fill_d = fill_next;
          end
        end
      end
      grs_pkg::StDrain: begin
        if (emit) begin
          // Newest word sits in cell zero, oldest at the cell of index rem - 1.
          out_valid_d = 1'b1;
          out_val_d   = rev_q ? cell_data[0] : cell_data[sel_idx];
          out_run_d   = (rem_q == CntW'(1));
          out_seq_d   = (rem_q == CntW'(1)) && fin_q;
          rem_d       = rem_q - CntW'(1);
          if (rev_q) begin
            cell_op = grs_pkg::CellPop;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= grs_pkg::StIdle;
      fill_q      <= '0;
      rem_q       <= '0;
      rev_q       <= 1'b0;
      fin_q       <= 1'b0;
      gs_q        <= grs_pkg::GsW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      rev_q       <= rev_d;
      fin_q       <= fin_d;
      gs_q        <= gs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= out_val_d;
    out_run_q <= out_run_d;
    out_seq_q <= out_seq_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.value_res    = out_val_q;
  assign out_o.run_end      = out_run_q;
  assign out_o.sequence_end = out_seq_q;

  // Assertions.
  a_drain_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (group_full || in_i.is_final)) |=> (state_q == grs_pkg::StDrain))
    else $error("completed group did not start draining");

  a_drain_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == grs_pkg::StDrain) |-> (rem_q != '0))
    else $error("drain running with nothing left");

  a_seq_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_seq_q) |-> out_run_q)
    else $error("sequence end without run end");

  // A lowered group size may leave the fill at or above it until the next
  // element arrives, so only the chain length bounds the fill here.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == grs_pkg::StIdle) |-> (32'(fill_q) < 32'(MAX_GROUP)))
    else $error("buffer fill reached chain length while idle");

endmodule
